// ===== rtl/core/rki_pkg.sv =====
package rki_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RANGE_LOW     = 2'd0,
		CFG_RANGE_HIGH    = 2'd1,
		CFG_DEBOUNCE_TIME = 2'd2
	} cfg_index_t;

	// switch debounce settings
	localparam int DEBOUNCE_BITS = 10;
	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_DEFAULT_MS = 10'd50;

	// pending delta and timestamp widths
	localparam int DELTA_BITS = 8;
	localparam int NOW_BITS   = 32;

endpackage

// ===== rtl/core/rotary_knob_interface.sv =====
// rotary knob interface: encoder step decode, clamped position, saturating delta,
// debounced push switch with latched press flag
// input beat to result beat: input register, then result register
// throughput: one poll per cycle; the result register stalls the input stage only
// while its beat is not taken, and configuration writes wait for an empty input stage
// reset: async active-low arst_n resets control state and loads the default registers
module rotary_knob_interface #(
	parameter int VALUE_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// clk_level, dt_level, switch_level, now_ms, take_delta, take_press,
	// load_value, new_value, zero fill
	input  logic [((3 + rki_pkg::NOW_BITS + 3 + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// position, delta, pressed, button_down, zero fill
	output logic [((VALUE_BITS + rki_pkg::DELTA_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rki_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [((VALUE_BITS > rki_pkg::DEBOUNCE_BITS) ? VALUE_BITS
		: rki_pkg::DEBOUNCE_BITS) - 1:0]        cfg_data
);

	localparam int NB     = rki_pkg::NOW_BITS;
	localparam int DB     = rki_pkg::DEBOUNCE_BITS;
	localparam int DLB    = rki_pkg::DELTA_BITS;
	localparam int IN_BITS  = 3 + NB + 3 + VALUE_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = VALUE_BITS + DLB + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_W    = (VALUE_BITS > DB) ? VALUE_BITS : DB;

	localparam int P_NOW   = 3;
	localparam int P_TAKED = P_NOW + NB;
	localparam int P_TAKEP = P_TAKED + 1;
	localparam int P_LOAD  = P_TAKEP + 1;
	localparam int P_NEWV  = P_LOAD + 1;

	// clamp checks the low bound first, then the high bound
	function automatic logic signed [VALUE_BITS-1:0] clamp_val(
		input logic signed [VALUE_BITS:0]   v,
		input logic signed [VALUE_BITS-1:0] lo,
		input logic signed [VALUE_BITS-1:0] hi
	);
		logic signed [VALUE_BITS:0] r;
		begin
			r = v;
			if (r < $signed({lo[VALUE_BITS-1], lo})) r = $signed({lo[VALUE_BITS-1], lo});
			if (r > $signed({hi[VALUE_BITS-1], hi})) r = $signed({hi[VALUE_BITS-1], hi});
			return r[VALUE_BITS-1:0];
		end
	endfunction

	// configuration registers
	logic signed [VALUE_BITS-1:0] range_low_q, range_high_q;
	logic [DB-1:0]                debounce_q;

	// block state
	logic                         last_clk_q;
	logic signed [DLB-1:0]        pending_q;
	logic signed [VALUE_BITS-1:0] knob_q;
	logic                         sw_raw_q, sw_stable_q, press_q;
	logic [TIME_BITS-1:0]         change_time_q;

	// input stage
	logic                         valid_s1;
	logic                         clk_s1, dt_s1, sw_s1, taked_s1, takep_s1, load_s1;
	logic [TIME_BITS-1:0]         now_s1;
	logic signed [VALUE_BITS-1:0] newv_s1;

	// result register
	logic                         out_valid_q;
	logic signed [VALUE_BITS-1:0] pos_q;
	logic signed [DLB-1:0]        delta_q;
	logic                         pressed_q, down_q;

	logic advance, in_fire, cfg_fire;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = !valid_s1;
	assign cfg_fire      = cfg_valid && cfg_ready;

	// next state for the poll in the input stage
	logic                         fall, step_up, raw, sw_change, sw_accept;
	logic signed [DLB:0]          pend_sum;
	logic signed [DLB-1:0]        pend_rot, pend_n, delta_n;
	logic signed [VALUE_BITS:0]   knob_sum;
	logic signed [VALUE_BITS-1:0] knob_rot, knob_n;
	logic [TIME_BITS-1:0]         elapsed;
	logic                         stable_n, press_set, press_n, pressed_n;

	always_comb begin
		fall    = (clk_s1 != last_clk_q) && !clk_s1;
		step_up = dt_s1 != clk_s1;

		// rotation
		pend_sum = $signed({pending_q[DLB-1], pending_q})
			+ (step_up ? $signed((DLB+1)'(1)) : $signed({(DLB+1){1'b1}}));
		if (pend_sum > $signed((DLB+1)'(127))) pend_rot = $signed(DLB'(127));
		else if (pend_sum < $signed({2'b11, {(DLB-1){1'b0}}}))
			pend_rot = $signed({1'b1, {(DLB-1){1'b0}}});
		else pend_rot = pend_sum[DLB-1:0];
		knob_sum = $signed({knob_q[VALUE_BITS-1], knob_q})
			+ (step_up ? $signed((VALUE_BITS+1)'(1)) : $signed({(VALUE_BITS+1){1'b1}}));
		knob_rot = fall ? clamp_val(knob_sum, range_low_q, range_high_q) : knob_q;
		pend_n   = fall ? pend_rot : pending_q;

		// switch debounce
		raw       = !sw_s1;
		sw_change = raw != sw_raw_q;
		elapsed   = now_s1 - change_time_q;
		sw_accept = !sw_change && (elapsed >= {{(TIME_BITS-DB){1'b0}}, debounce_q})
			&& (raw != sw_stable_q);
		stable_n  = sw_accept ? raw : sw_stable_q;
		press_set = sw_accept && raw;

		// value load
		knob_n = load_s1 ? clamp_val($signed({newv_s1[VALUE_BITS-1], newv_s1}),
			range_low_q, range_high_q) : knob_rot;

		// reports
		delta_n   = taked_s1 ? pend_n : '0;
		press_n   = press_q || press_set;
		pressed_n = takep_s1 && press_n;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			clk_s1   <= s_axis_tdata[0];
			dt_s1    <= s_axis_tdata[1];
			sw_s1    <= s_axis_tdata[2];
			now_s1   <= s_axis_tdata[P_NOW +: TIME_BITS];
			taked_s1 <= s_axis_tdata[P_TAKED];
			takep_s1 <= s_axis_tdata[P_TAKEP];
			load_s1  <= s_axis_tdata[P_LOAD];
			newv_s1  <= $signed(s_axis_tdata[P_NEWV +: VALUE_BITS]);
		end
	end

	// state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q   <= $signed({1'b1, {(VALUE_BITS-1){1'b0}}});
			range_high_q  <= $signed({1'b0, {(VALUE_BITS-1){1'b1}}});
			debounce_q    <= rki_pkg::DEBOUNCE_DEFAULT_MS;
			last_clk_q    <= 1'b1;
			pending_q     <= '0;
			knob_q        <= '0;
			sw_raw_q      <= 1'b0;
			sw_stable_q   <= 1'b0;
			press_q       <= 1'b0;
			change_time_q <= '0;
		end else if (cfg_fire) begin
			case (rki_pkg::cfg_index_t'(cfg_index))
				rki_pkg::CFG_RANGE_LOW: begin
					range_low_q <= $signed(cfg_data[VALUE_BITS-1:0]);
					knob_q <= clamp_val($signed({knob_q[VALUE_BITS-1], knob_q}),
						$signed(cfg_data[VALUE_BITS-1:0]), range_high_q);
				end
				rki_pkg::CFG_RANGE_HIGH: begin
					range_high_q <= $signed(cfg_data[VALUE_BITS-1:0]);
					knob_q <= clamp_val($signed({knob_q[VALUE_BITS-1], knob_q}),
						range_low_q, $signed(cfg_data[VALUE_BITS-1:0]));
				end
				rki_pkg::CFG_DEBOUNCE_TIME: begin
					debounce_q <= cfg_data[DB-1:0];
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			last_clk_q  <= clk_s1;
			pending_q   <= taked_s1 ? '0 : pend_n;
			knob_q      <= knob_n;
			sw_raw_q    <= raw;
			sw_stable_q <= stable_n;
			press_q     <= takep_s1 ? 1'b0 : press_n;
			if (sw_change) change_time_q <= now_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_q     <= knob_n;
			delta_q   <= delta_n;
			pressed_q <= pressed_n;
			down_q    <= stable_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({down_q, pressed_q, delta_q, pos_q});

`ifndef NO_ASSERTIONS
	// position stays inside a proper range
	a_knob_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(range_low_q <= range_high_q) |-> (knob_q >= range_low_q && knob_q <= range_high_q))
		else $error("knob value outside configured range");

	// stable switch level only moves to the raw level
	a_stable_follows_raw: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sw_stable_q) |-> (sw_stable_q == sw_raw_q))
		else $error("debounced level changed away from raw level");

	// press flag is set only by a newly accepted press
	a_press_on_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(press_q) |-> $rose(sw_stable_q))
		else $error("press latched without a debounced press");

	// the result beat reports the updated position and debounced switch level
	a_result_position: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> (pos_q == knob_q && down_q == sw_stable_q))
		else $error("result beat disagrees with block state");
`endif

endmodule
